// ----- hdl/assert_macros.svh -----
// assertion macros shared by the meter data record decoder
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MDRD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// condition must never be true
`define MDRD_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition");

`endif

// ----- hdl/mdrd_pkg.sv -----
// types, constants and helper functions of the meter data record decoder
// no dependencies; used by mdrd_parser and meter_data_record_decoder
package mdrd_pkg;

    localparam int OFFSET_BITS = 8;

    localparam logic [7:0] END_MARK = 8'h2F;

    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_BAD    = 2'd2;
    localparam logic [1:0] KIND_TRUNC  = 2'd3;

    localparam logic [2:0] UNIT_NONE   = 3'd0;
    localparam logic [2:0] UNIT_WH     = 3'd1;
    localparam logic [2:0] UNIT_KWH    = 3'd2;
    localparam logic [2:0] UNIT_VOLUME = 3'd3;
    localparam logic [2:0] UNIT_FLOW_T = 3'd4;
    localparam logic [2:0] UNIT_RET_T  = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  dif_byte;
        logic [7:0]  vif_byte;
        logic [2:0]  unit_code;
        logic [63:0] record_value;
        logic [3:0]  value_length;
        logic        value_not_available;
        logic [7:0]  record_number;
        logic [7:0]  record_offset;
        logic        done_res;
    } t_res_item;

    typedef struct packed {
        logic      valid;
        t_res_item item;
    } t_step_res;

    // data byte count from the dif low nibble
    function automatic logic [3:0] len_of_dif(input logic [7:0] dif);
        logic [3:0] len;
        case (dif[3:0])
            4'd5:    len = 4'd4;
            4'd6:    len = 4'd6;
            4'd7:    len = 4'd8;
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: len = dif[3:0];
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] unit_of_vif(input logic [7:0] vif);
        logic [2:0] unit;
        unique case (vif[6:0])
            7'h06:   unit = UNIT_WH;
            7'h07:   unit = UNIT_KWH;
            7'h13:   unit = UNIT_VOLUME;
            7'h5B:   unit = UNIT_FLOW_T;
            7'h5C:   unit = UNIT_RET_T;
            default: unit = UNIT_NONE;
        endcase
        return unit;
    endfunction

    // byte position clipped to the 8 bit offset field
    function automatic logic [7:0] sat_off(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS-1:0] lim;
        lim = OFFSET_BITS'(8'hFF);
        return (v > lim) ? 8'hFF : v[7:0];
    endfunction

endpackage

// ----- hdl/meter_data_record_decoder.sv -----
// Meter data record decoder. Takes one decrypted payload byte per clock unless
// stalled, skips start_offset leading bytes and parses dif/dife/vif/vife/data
// records, giving at most one result per byte. Throughput is one byte per
// cycle; a result appears in the output register the cycle after the byte that
// completes it. The whole parse step is a single pass through mdrd_parser,
// so the only reason to stall input is a full result register that is itself
// stalled. start_offset is written through the config channel, which is always
// ready. Depends on mdrd_pkg, mdrd_parser and assert_macros.svh.
`include "assert_macros.svh"

module meter_data_record_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mdrd_pkg::t_in_item  i_in_data,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output mdrd_pkg::t_res_item o_res_data
);
    import mdrd_pkg::*;

    logic [7:0] r_start_offset;
    logic       r_res_valid, n_res_valid;
    t_res_item  r_res;
    logic       in_accept;
    t_step_res  step;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_res_valid & i_res_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;

    mdrd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_accept),
        .i_item         (i_in_data),
        .i_start_offset (r_start_offset),
        .o_res          (step)
    );

    // result register keeps its transaction while stalled downstream
    assign n_res_valid = in_accept ? step.valid : (r_res_valid & i_res_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset <= '0;
            r_res_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_start_offset <= i_cfg_data;
            end
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && step.valid) begin
            r_res <= step.item;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res;

    `MDRD_ASSERT_IMPLIES(a_stop_is_final, i_clk, i_rst_n, o_res_valid && o_res_data.kind != KIND_RECORD, o_res_data.done_res)
    `MDRD_ASSERT_IMPLIES(a_stop_has_no_value, i_clk, i_rst_n, o_res_valid && (o_res_data.kind == KIND_END || o_res_data.kind == KIND_BAD), o_res_data.record_value == 64'd0 && o_res_data.value_length == 4'd0 && o_res_data.vif_byte == 8'd0)
    `MDRD_ASSERT_IMPLIES(a_nav_length, i_clk, i_rst_n, o_res_valid && o_res_data.value_not_available, o_res_data.value_length == 4'd1 || o_res_data.value_length == 4'd2 || o_res_data.value_length == 4'd4)
    `MDRD_ASSERT_NEVER(a_length_range, i_clk, i_rst_n, o_res_valid && o_res_data.value_length > 4'd8)

endmodule

// ----- hdl/mdrd_parser.sv -----
// byte-serial dif/vif record parser: phase state and the one-pass step logic
// depends on mdrd_pkg
module mdrd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  mdrd_pkg::t_in_item i_item,
    input  logic [7:0]         i_start_offset,
    output mdrd_pkg::t_step_res o_res
);
    import mdrd_pkg::*;

    typedef enum logic [2:0] {
        PH_SKIP = 3'd0,
        PH_DIF  = 3'd1,
        PH_DIFE = 3'd2,
        PH_VIF  = 3'd3,
        PH_VIFE = 3'd4,
        PH_DATA = 3'd5
    } t_phase;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    t_phase                 r_phase, n_phase;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [7:0]             r_dif, n_dif;
    logic [7:0]             r_vif, n_vif;
    logic [3:0]             r_left, n_left;
    logic [63:0]            r_acc, n_acc;
    logic [7:0]             r_seen, n_seen;
    logic [OFFSET_BITS-1:0] r_hdr, n_hdr;
    logic                   r_stopped, n_stopped;

    logic [7:0] b;
    logic       take;
    logic       emit;
    logic [2:0] lane;
    logic [3:0] emit_len;
    t_step_res  res;

    assign b = i_item.data_byte;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = (r_pos != POS_MAX) ? r_pos + OFFSET_BITS'(1) : r_pos;
        n_dif     = r_dif;
        n_vif     = r_vif;
        n_left    = r_left;
        n_acc     = r_acc;
        n_seen    = r_seen;
        n_hdr     = r_hdr;
        n_stopped = r_stopped;
        take      = 1'b0;
        emit      = 1'b0;
        res       = '0;
        lane      = 3'(len_of_dif(r_dif) - r_left);
        emit_len  = '0;

        if (!r_stopped) begin
            unique case (r_phase)
                PH_SKIP: begin
                    if (r_pos >= OFFSET_BITS'(i_start_offset)) begin
                        take = 1'b1;
                    end
                end
                PH_DIF: begin
                    take = 1'b1;
                end
                PH_DIFE: begin
                    if (!b[7]) begin
                        n_phase = PH_VIF;
                    end
                end
                PH_VIF: begin
                    n_vif = b;
                    if (b[7]) begin
                        n_phase = PH_VIFE;
                    end else if (r_left == 4'd0) begin
                        emit = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_VIFE: begin
                    if (!b[7]) begin
                        if (r_left == 4'd0) begin
                            emit = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_acc  = r_acc | ({56'd0, b} << {lane, 3'b000});
                    n_left = (r_left != 4'd0) ? r_left - 4'd1 : r_left;
                    emit   = (n_left == 4'd0);
                end
                default: begin
                    n_phase = PH_SKIP;
                end
            endcase
        end

        if (take) begin
            if (b == END_MARK || b[3:0] > 4'd7) begin
                res.valid              = 1'b1;
                res.item.kind          = (b == END_MARK) ? KIND_END : KIND_BAD;
                res.item.dif_byte      = b;
                res.item.record_number = r_seen;
                res.item.record_offset = sat_off(r_pos);
                res.item.done_res      = 1'b1;
                n_stopped              = 1'b1;
            end else begin
                n_dif   = b;
                n_vif   = '0;
                n_acc   = '0;
                n_left  = len_of_dif(b);
                n_hdr   = r_pos;
                n_phase = b[7] ? PH_DIFE : PH_VIF;
            end
        end

        if (emit) begin
            emit_len = len_of_dif(n_dif);
            n_seen   = (r_seen != 8'hFF) ? r_seen + 8'd1 : r_seen;
            n_phase  = PH_DIF;
            res.valid                    = 1'b1;
            res.item.kind                = KIND_RECORD;
            res.item.dif_byte            = n_dif;
            res.item.vif_byte            = n_vif;
            res.item.unit_code           = unit_of_vif(n_vif);
            res.item.record_value        = n_acc;
            res.item.value_length        = emit_len;
            res.item.value_not_available =
                (emit_len == 4'd4 && n_acc == 64'h0000_0000_FFFF_FFFF) ||
                (emit_len == 4'd2 && n_acc == 64'h0000_0000_0000_FFFF) ||
                (emit_len == 4'd1 && n_acc == 64'h0000_0000_0000_00FF);
            res.item.record_number       = n_seen;
            res.item.record_offset       = sat_off(r_hdr);
        end

        if (i_item.last_byte) begin
            if (res.valid) begin
                res.item.done_res = 1'b1;
            end else if (!r_stopped) begin
                // payload ended in skip phase or mid record
                res.valid              = 1'b1;
                res.item.kind          = KIND_TRUNC;
                res.item.dif_byte      = n_dif;
                res.item.vif_byte      = n_vif;
                res.item.record_number = n_seen;
                res.item.record_offset = sat_off(n_hdr);
                res.item.done_res      = 1'b1;
            end
            // re-arm for the next payload
            n_phase   = PH_SKIP;
            n_pos     = '0;
            n_dif     = '0;
            n_vif     = '0;
            n_left    = '0;
            n_acc     = '0;
            n_seen    = '0;
            n_hdr     = '0;
            n_stopped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SKIP;
            r_pos     <= '0;
            r_dif     <= '0;
            r_vif     <= '0;
            r_left    <= '0;
            r_acc     <= '0;
            r_seen    <= '0;
            r_hdr     <= '0;
            r_stopped <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_dif     <= n_dif;
            r_vif     <= n_vif;
            r_left    <= n_left;
            r_acc     <= n_acc;
            r_seen    <= n_seen;
            r_hdr     <= n_hdr;
            r_stopped <= n_stopped;
        end
    end

    assign o_res = res;

endmodule
